// ===== rtl/abx_pkg.sv =====
// shared types and constants for the annex b to length-prefixed converter
// no dependencies
package abx_pkg;

   localparam int LENGTH_BITS = 32;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   // most words one input byte can cause, and depth of the result queue
   localparam int MAX_RES   = 6;
   localparam int RES_DEPTH = 8;
   localparam int PTR_BITS  = $clog2(RES_DEPTH);
   localparam int IDX_BITS  = $clog2(MAX_RES + 1);

   // start code lengths
   localparam logic [2:0] CODE_NONE  = 3'd0;
   localparam logic [2:0] CODE_SHORT = 3'd3;
   localparam logic [2:0] CODE_LONG  = 3'd4;

   typedef enum logic [1:0] {
      KIND_LEAD = 2'd0,
      KIND_UNIT = 2'd1,
      KIND_LEN  = 2'd2,
      KIND_END  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [2:0][7:0]        bytes;
      logic [1:0]             count;
      logic [1:0]             skip;
      logic                   in_unit;
      logic                   found;
      logic [LENGTH_BITS-1:0] len;
   } scan_state_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             data;
      logic [LENGTH_BITS-1:0] len;
      logic                   seen;
      logic                   last;
   } res_word_type;

endpackage

// ===== rtl/annexb_to_length_prefixed.sv =====
// annex b start code stripper with trailing unit length records
// a word enters the registered result queue when the byte that causes it is taken
// throughput: one byte per cycle while the eight-entry result queue holds at most
// two words; a packet end pushes up to six words, which drain one per cycle while
// the receiver is ready, so the byte after a packet end may wait for them to drain
// reset: synchronous, active high; empties the queue and clears the scan state
module annexb_to_length_prefixed (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_packet_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_type,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_unit_length,
   output logic        rsp_start_code_seen,
   output logic        rsp_last_result
);

   // scan state: look-ahead window, skip count, unit flags, running length
   abx_pkg::scan_state_type state_ff;
   abx_pkg::scan_state_type state_in;

   // words from the scanner for the byte on the request side
   abx_pkg::res_word_type [abx_pkg::MAX_RES-1:0] res_list;
   logic [abx_pkg::IDX_BITS-1:0]                 res_count;

   // result queue
   abx_pkg::res_word_type        queue_ff [abx_pkg::RES_DEPTH];
   logic [abx_pkg::PTR_BITS-1:0] wr_ptr_ff;
   logic [abx_pkg::PTR_BITS-1:0] rd_ptr_ff;
   logic [abx_pkg::PTR_BITS:0]   occ_ff;
   logic [abx_pkg::PTR_BITS:0]   occ_in;

   logic req_take;
   logic rsp_take;
   abx_pkg::res_word_type head;

   abx_scan u_scan (
      .cur_state  (state_ff),
      .data_byte  (req_data_byte),
      .packet_end (req_packet_end),
      .nxt_state  (state_in),
      .res_list   (res_list),
      .res_count  (res_count)
   );

   // room for a whole packet-end burst is needed before a byte is taken
   assign req_ready = (occ_ff <= (abx_pkg::PTR_BITS + 1)'(abx_pkg::RES_DEPTH - abx_pkg::MAX_RES));
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (occ_ff != '0);
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      occ_in = occ_ff;
      if (req_take) begin
         occ_in = occ_in + (abx_pkg::PTR_BITS + 1)'(res_count);
      end
      if (rsp_take) begin
         occ_in = occ_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         occ_ff <= occ_in;
         if (req_take) begin
            state_ff  <= state_in;
            wr_ptr_ff <= wr_ptr_ff + abx_pkg::PTR_BITS'(res_count);
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // queue storage, written in order from the write pointer onward
   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int j = 0; j < abx_pkg::MAX_RES; j++) begin
            if (abx_pkg::IDX_BITS'(j) < res_count) begin
               queue_ff[abx_pkg::PTR_BITS'(wr_ptr_ff + abx_pkg::PTR_BITS'(j))] <= res_list[j];
            end
         end
      end
   end

   assign head                = queue_ff[rd_ptr_ff];
   assign rsp_result_type     = head.kind;
   assign rsp_out_byte        = head.data;
   assign rsp_unit_length     = 32'(head.len);
   assign rsp_start_code_seen = head.seen;
   assign rsp_last_result     = head.last;

endmodule

// ===== rtl/abx_scan.sv =====
// start code search and result list for one input byte
// depends on abx_pkg
module abx_scan (
   input  abx_pkg::scan_state_type                 cur_state,
   input  logic [7:0]                              data_byte,
   input  logic                                    packet_end,
   output abx_pkg::scan_state_type                 nxt_state,
   output abx_pkg::res_word_type [abx_pkg::MAX_RES-1:0] res_list,
   output logic [abx_pkg::IDX_BITS-1:0]            res_count
);

   logic [3:0][7:0]                 win;
   logic                            full;
   logic [2:0]                      code;
   logic [1:0]                      skip;
   logic                            in_unit;
   logic                            found;
   logic [abx_pkg::LENGTH_BITS-1:0] len;
   logic [1:0]                      extra;
   logic [abx_pkg::LENGTH_BITS:0]   len_sum;
   logic [abx_pkg::LENGTH_BITS-1:0] len_final;
   logic [abx_pkg::IDX_BITS-1:0]    n;

   always_comb begin
      win[0] = (cur_state.count == 2'd0) ? data_byte : cur_state.bytes[0];
      win[1] = (cur_state.count == 2'd1) ? data_byte : cur_state.bytes[1];
      win[2] = (cur_state.count == 2'd2) ? data_byte : cur_state.bytes[2];
      win[3] = data_byte;
      full   = (cur_state.count == 2'd3);

      code = abx_pkg::CODE_NONE;
      if (win[0] == 8'h00 && win[1] == 8'h00) begin
         if (win[2] == 8'h01) begin
            code = abx_pkg::CODE_SHORT;
         end else if (win[2] == 8'h00 && win[3] == 8'h01) begin
            code = abx_pkg::CODE_LONG;
         end
      end

      skip      = cur_state.skip;
      in_unit   = cur_state.in_unit;
      found     = cur_state.found;
      len       = cur_state.len;
      extra     = 2'd0;
      n         = '0;
      res_list  = '0;
      nxt_state = cur_state;

      // oldest byte, with the full four-byte window
      if (full) begin
         if (skip != 2'd0) begin
            skip = skip - 2'd1;
         end else if (code != abx_pkg::CODE_NONE) begin
            if (in_unit) begin
               res_list[n].kind = abx_pkg::KIND_LEN;
               res_list[n].len  = len;
               n = n + 1'b1;
            end
            in_unit = 1'b1;
            found   = 1'b1;
            len     = '0;
            skip    = 2'(code - 3'd1);
         end else begin
            res_list[n].kind = in_unit ? abx_pkg::KIND_UNIT : abx_pkg::KIND_LEAD;
            res_list[n].data = win[0];
            n = n + 1'b1;
            if (in_unit && len != abx_pkg::LEN_MAX) begin
               len = len + 1'b1;
            end
         end
      end

      if (packet_end) begin
         // flush: too few bytes left for a start code
         for (int p = 0; p < 4; p++) begin
            if ((p != 0 || !full) && 2'(p) <= cur_state.count) begin
               if (skip != 2'd0) begin
                  skip = skip - 2'd1;
               end else begin
                  res_list[n].kind = in_unit ? abx_pkg::KIND_UNIT : abx_pkg::KIND_LEAD;
                  res_list[n].data = win[p];
                  n = n + 1'b1;
                  if (in_unit) begin
                     extra = extra + 2'd1;
                  end
               end
            end
         end
         len_sum   = {1'b0, len} + (abx_pkg::LENGTH_BITS + 1)'(extra);
         len_final = len_sum[abx_pkg::LENGTH_BITS] ? abx_pkg::LEN_MAX
                                                   : len_sum[abx_pkg::LENGTH_BITS-1:0];
         if (in_unit) begin
            res_list[n].kind = abx_pkg::KIND_LEN;
            res_list[n].len  = len_final;
            n = n + 1'b1;
         end
         res_list[n].kind = abx_pkg::KIND_END;
         res_list[n].seen = found;
         n = n + 1'b1;
         nxt_state = '0;
      end else begin
         len_sum   = '0;
         len_final = '0;
         if (full) begin
            nxt_state.bytes[0] = win[1];
            nxt_state.bytes[1] = win[2];
            nxt_state.bytes[2] = win[3];
            nxt_state.count    = 2'd3;
         end else begin
            nxt_state.bytes[cur_state.count] = data_byte;
            nxt_state.count = cur_state.count + 2'd1;
         end
         nxt_state.skip    = skip;
         nxt_state.in_unit = in_unit;
         nxt_state.found   = found;
         nxt_state.len     = len;
      end

      if (n != '0) begin
         res_list[n - 1'b1].last = 1'b1;
      end
      res_count = n;
   end

endmodule

// ===== tb/annexb_to_length_prefixed_tb.sv =====
// self-checking bench for the annex b to length-prefixed converter: directed packets,
// then random well-formed and broken packets under changing idle patterns
// depends on abx_pkg and annexb_to_length_prefixed
module annexb_to_length_prefixed_tb;

   localparam int HOLD_LEN     = 150;   // long receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 8;     // settle time once nothing is expected
   localparam int ITEMS_PER_PHASE = 88;

   typedef struct {
      logic [7:0] data;
      logic       pkt_end;
   } stream_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_packet_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_type;
   logic [7:0]  rsp_out_byte;
   logic [31:0] rsp_unit_length;
   logic        rsp_start_code_seen;
   logic        rsp_last_result;

   // stimulus and expectation stores
   stream_word_type       pending_bytes[$];
   abx_pkg::res_word_type expected_words[$];
   int                    queued_total = 0;
   int                    mismatch_count = 0;

   // idle percentages per side, changed between phases
   int send_idle_pct = 30;
   int recv_idle_pct = 66;

   // long receiver hold-off, requested by the stimulus and timed by its own process
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   int   hold_cycles = 0;

   // predictor state: undecided bytes, start code skip, open unit and its length
   logic [7:0]                      held_bytes [0:2];
   int                              held_count = 0;
   int                              skip_left = 0;
   logic                            in_unit = 1'b0;
   logic                            seen_any = 1'b0;
   logic [abx_pkg::LENGTH_BITS-1:0] unit_len = '0;
   logic [7:0]                      scan_win [0:3];

   annexb_to_length_prefixed dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_packet_end      (req_packet_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_type     (rsp_result_type),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_unit_length     (rsp_unit_length),
      .rsp_start_code_seen (rsp_start_code_seen),
      .rsp_last_result     (rsp_last_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   task automatic add_expected(input abx_pkg::kind_type kind, input logic [7:0] data,
                               input logic [abx_pkg::LENGTH_BITS-1:0] len,
                               input logic seen);
      abx_pkg::res_word_type w;
      w.kind = kind;
      w.data = data;
      w.len  = len;
      w.seen = seen;
      w.last = 1'b0;
      expected_words = {expected_words, w};
   endtask

   // settle the oldest byte of the window at position at, avail bytes known from it
   task automatic settle_oldest(input int at, input int avail);
      logic [2:0] code_len;
      code_len = abx_pkg::CODE_NONE;
      // tail of a start code already found
      if (skip_left > 0) begin
         skip_left = skip_left - 1;
         return;
      end
      // full look-ahead needed: a short code right at packet end does not count
      if (avail >= 4 && scan_win[at] == 8'h00 && scan_win[at+1] == 8'h00) begin
         if (scan_win[at+2] == 8'h01)
            code_len = abx_pkg::CODE_SHORT;
         else if (scan_win[at+2] == 8'h00 && scan_win[at+3] == 8'h01)
            code_len = abx_pkg::CODE_LONG;
      end
      if (code_len != abx_pkg::CODE_NONE) begin
         // a new code closes the open unit, even an empty one
         if (in_unit)
            add_expected(abx_pkg::KIND_LEN, 8'h00, unit_len, 1'b0);
         in_unit   = 1'b1;
         seen_any  = 1'b1;
         unit_len  = '0;
         skip_left = int'(code_len) - 1;
         return;
      end
      if (in_unit) begin
         add_expected(abx_pkg::KIND_UNIT, scan_win[at], '0, 1'b0);
         if (unit_len < abx_pkg::LEN_MAX)
            unit_len = unit_len + 1'b1;
      end else begin
         add_expected(abx_pkg::KIND_LEAD, scan_win[at], '0, 1'b0);
      end
   endtask

   // expected words for one accepted byte
   task automatic predict_byte(input logic [7:0] data, input logic pkt_end);
      int n;
      int at;
      int i;
      int words_before;
      words_before = expected_words.size();
      n = held_count;
      for (i = 0; i < n; i++)
         scan_win[i] = held_bytes[i];
      scan_win[n] = data;
      n++;
      at = 0;
      if (n == 4) begin
         settle_oldest(0, 4);
         at = 1;
      end
      if (pkt_end) begin
         // flush what is left, close the unit, then the packet record
         while (at < n) begin
            settle_oldest(at, n - at);
            at++;
         end
         if (in_unit)
            add_expected(abx_pkg::KIND_LEN, 8'h00, unit_len, 1'b0);
         add_expected(abx_pkg::KIND_END, 8'h00, '0, seen_any);
         // every packet stands on its own
         for (i = 0; i < 3; i++)
            held_bytes[i] = 8'h00;
         held_count = 0;
         skip_left  = 0;
         in_unit    = 1'b0;
         seen_any   = 1'b0;
         unit_len   = '0;
      end else begin
         held_count = n - at;
         for (i = 0; i < held_count; i++)
            held_bytes[i] = scan_win[at + i];
      end
      if (expected_words.size() > words_before)
         expected_words[expected_words.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report(input string field, input longint unsigned want,
                         input longint unsigned got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   task automatic check_word(input abx_pkg::res_word_type got);
      abx_pkg::res_word_type want;
      if (expected_words.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected word, expected none, actual type %0d byte %0h len %0h",
                  $time, got.kind, got.data, got.len);
         return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind) report("result_type", want.kind, got.kind);
      if (got.data !== want.data) report("out_byte", want.data, got.data);
      if (got.len  !== want.len)  report("unit_length", want.len, got.len);
      if (got.seen !== want.seen) report("start_code_seen", want.seen, got.seen);
      if (got.last !== want.last) report("last_result", want.last, got.last);
   endtask

   // ---------------------------------------------------------------- driver

   // offers the next queued byte, idling at random; payload holds until taken
   always @(posedge clock) begin : byte_driver
      stream_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_bytes.pop_front();
            req_valid      <= 1'b1;
            req_data_byte  <= nxt.data;
            req_packet_end <= nxt.pkt_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // predicts on every byte taken, then checks every word taken, in that order
   always @(posedge clock) begin : word_monitor
      abx_pkg::res_word_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_byte(req_data_byte, req_packet_end);
         if (rsp_valid && rsp_ready) begin
            got.kind = abx_pkg::kind_type'(rsp_result_type);
            got.data = rsp_out_byte;
            got.len  = rsp_unit_length;
            got.seen = rsp_start_code_seen;
            got.last = rsp_last_result;
            check_word(got);
         end
         rsp_ready <= !(hold_req && !hold_done) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // times the long hold-off so the result queue fills and the input stalls
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         if (hold_cycles >= HOLD_LEN)
            hold_done <= 1'b1;
         else
            hold_cycles <= hold_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_packet(input logic [7:0] bytes[$]);
      stream_word_type w;
      int i;
      for (i = 0; i < bytes.size(); i++) begin
         w.data    = bytes[i];
         w.pkt_end = (i == bytes.size() - 1);
         pending_bytes = {pending_bytes, w};
         queued_total++;
      end
   endtask

   // biased towards zeros and ones so near-misses of start codes turn up often
   function automatic logic [7:0] pick_payload_byte();
      int r;
      r = $urandom_range(9);
      if (r < 3)
         return 8'h00;
      else if (r == 3)
         return 8'h01;
      else
         return 8'($urandom);
   endfunction

   task automatic add_random_packet();
      logic [7:0] bytes[$];
      int units;
      int len;
      int u;
      int i;
      if ($urandom_range(99) < 80) begin
         // well-formed: optional leading bytes, then units behind start codes
         len = $urandom_range(2);
         for (i = 0; i < len; i++)
            bytes = {bytes, pick_payload_byte()};
         units = $urandom_range(1, 3);
         for (u = 0; u < units; u++) begin
            if ($urandom_range(1))
               bytes = {bytes, 8'h00};
            bytes = {bytes, 8'h00, 8'h00, 8'h01};
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            for (i = 0; i < len; i++)
               bytes = {bytes, pick_payload_byte()};
         end
      end else begin
         // noise, and the odd broken code
         len = $urandom_range(1, 8);
         for (i = 0; i < len; i++)
            bytes = {bytes, pick_payload_byte()};
      end
      queue_packet(bytes);
   endtask

   // sender pause: nothing offered until every expected word has come
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_random_phase();
      int target;
      target = queued_total + ITEMS_PER_PHASE;
      while (queued_total < target)
         add_random_packet();
   endtask

   initial begin
      logic [7:0] pkt[$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // leading byte, short code, payload, long code, last payload byte
      pkt = '{8'h11, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80};
      queue_packet(pkt);
      // two codes back to back give an empty unit
      pkt = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h7F};
      queue_packet(pkt);
      // short code as the last bytes does not count: all leading
      pkt = '{8'h42, 8'h00, 8'h00, 8'h01};
      queue_packet(pkt);
      // long code as the whole packet opens an empty unit
      pkt = '{8'h00, 8'h00, 8'h00, 8'h01};
      queue_packet(pkt);
      // single byte packet
      pkt = '{8'h00};
      queue_packet(pkt);
      run_random_phase();
      wait_drained();

      // receiver now the quicker side
      send_idle_pct = 66;
      recv_idle_pct = 30;
      run_random_phase();
      wait_drained();

      // no idling, opening with a long receiver hold-off against a busy sender
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 1'b1;
      run_random_phase();
      wait_drained();

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // hang guard, far above the slowest correct run
   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
